### src/i32alu_pkg.sv
// ----------------------------------------------------------------------------
// i32alu_pkg: shared types and codes
// Operation codes, status codes and the transaction payload structs.
// ----------------------------------------------------------------------------
package i32alu_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_MOD = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;
    localparam logic [2:0] OP_DIV = 3'd5;
    localparam logic [2:0] OP_CMP = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
    } rsp_t;

    // Start command from the sequencer to the shared datapath.
    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } dp_cmd_t;

endpackage

### src/i32alu_core.sv
// ----------------------------------------------------------------------------
// i32alu_core: shared iterative datapath
// One adder/subtractor serves add, subtract, compare, shift-add multiply,
// restoring divide, and power by repeated multiplication.
// ----------------------------------------------------------------------------
module i32alu_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  i32alu_pkg::dp_cmd_t cmd,
    input  logic signed [31:0] a_in,
    input  logic signed [31:0] b_in,
    output logic               done,
    output i32alu_pkg::rsp_t   rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_PMUL = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  op_reg, op_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;     // product / remainder:quotient
    logic [31:0] mc_reg, mc_next;       // multiplicand or divisor magnitude
    logic [31:0] mp_reg, mp_next;       // multiplier bits
    logic        neg_reg, neg_next;     // sign of the product or quotient
    logic        rneg_reg, rneg_next;   // sign of the remainder
    logic [31:0] pbase_reg, pbase_next; // |base| for power
    logic        pneg_reg, pneg_next;   // base negative
    logic [31:0] pexp_reg, pexp_next;   // remaining exponent
    logic        pacc_neg_reg, pacc_neg_next;
    logic [1:0]  st_reg, st_next;
    logic signed [31:0] res_reg, res_next;
    logic        done_reg, done_next;

    // The single shared adder.
    logic [32:0] add_x, add_y, add_s;
    logic        add_sub;
    assign add_s = add_sub ? (add_x - add_y) : (add_x + add_y);

    logic [31:0] abs_a, abs_b;
    assign abs_a = a_in[31] ? (32'd0 - a_in) : a_in;
    assign abs_b = b_in[31] ? (32'd0 - b_in) : b_in;

    // Finish a signed magnitude with sign into a checked int32.
    function automatic logic [32:0] fit(input logic [63:0] mag, input logic neg);
        logic [32:0] r;
        begin
            r = {1'b1, 32'd0};
            if (!neg && mag <= 64'h7FFF_FFFF) r = {1'b0, mag[31:0]};
            else if (neg && mag <= 64'h8000_0000) r = {1'b0, 32'd0 - mag[31:0]};
            fit = r;
        end
    endfunction

    logic [32:0] fitv;
    logic [63:0] fit_mag;
    logic        fit_neg;

    always_comb begin
        state_next = state_reg; op_next = op_reg; cnt_next = cnt_reg;
        acc_next = acc_reg; mc_next = mc_reg; mp_next = mp_reg;
        neg_next = neg_reg; rneg_next = rneg_reg;
        pbase_next = pbase_reg; pneg_next = pneg_reg; pexp_next = pexp_reg;
        pacc_neg_next = pacc_neg_reg;
        st_next = st_reg; res_next = res_reg; done_next = 1'b0;
        add_x = 33'd0; add_y = 33'd0; add_sub = 1'b0;
        fit_mag = acc_reg; fit_neg = neg_reg;
        fitv = fit(fit_mag, fit_neg);
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.start) begin
                    op_next = cmd.op;
                    st_next = i32alu_pkg::ST_OK;
                    res_next = 32'sd0;
                    state_next = S_FIN;
                    case (cmd.op)
                        i32alu_pkg::OP_ADD, i32alu_pkg::OP_SUB: begin
                            add_x = {a_in[31], a_in};
                            add_y = {b_in[31], b_in};
                            add_sub = (cmd.op == i32alu_pkg::OP_SUB);
                            if (add_s[32] != add_s[31]) st_next = i32alu_pkg::ST_RANGE;
                            else res_next = add_s[31:0];
                        end
                        i32alu_pkg::OP_CMP: begin
                            add_x = {a_in[31], a_in};
                            add_y = {b_in[31], b_in};
                            add_sub = 1'b1;
                            if (add_s == 33'd0) res_next = 32'sd0;
                            else if (add_s[32]) res_next = -32'sd1;
                            else res_next = 32'sd1;
                        end
                        i32alu_pkg::OP_MUL: begin
                            acc_next = 64'd0; mc_next = abs_a; mp_next = abs_b;
                            neg_next = a_in[31] ^ b_in[31];
                            cnt_next = 6'd0; state_next = S_MUL;
                        end
                        i32alu_pkg::OP_DIV, i32alu_pkg::OP_MOD: begin
                            if (b_in == 32'sd0) begin
                                st_next = i32alu_pkg::ST_DIVZERO;
                            end else begin
                                acc_next = {32'd0, abs_a}; mc_next = abs_b;
                                neg_next = a_in[31] ^ b_in[31];
                                rneg_next = a_in[31];
                                cnt_next = 6'd0; state_next = S_DIV;
                            end
                        end
                        i32alu_pkg::OP_POW: begin
                            if (b_in == 32'sd0 || a_in == 32'sd1) begin
                                res_next = 32'sd1;
                            end else if (a_in == -32'sd1) begin
                                res_next = b_in[0] ? -32'sd1 : 32'sd1;
                            end else if (b_in[31]) begin
                                if (a_in == 32'sd0) st_next = i32alu_pkg::ST_RANGE;
                            end else if (a_in == 32'sd0) begin
                                res_next = 32'sd0;
                            end else begin
                                pbase_next = abs_a; pneg_next = a_in[31];
                                pexp_next = b_in; pacc_neg_next = 1'b0;
                                acc_next = 64'd1;
                                state_next = S_PMUL;
                            end
                        end
                        default: st_next = i32alu_pkg::ST_RANGE;
                    endcase
                end
            end
            S_MUL: begin
                // One shift-add step per cycle on the high half.
                add_x = {1'b0, acc_reg[63:32]};
                add_y = mp_reg[0] ? {1'b0, mc_reg} : 33'd0;
                acc_next = {add_s, acc_reg[31:1]};
                mp_next = {1'b0, mp_reg[31:1]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    state_next = S_FIN;
                    fit_mag = {add_s, acc_reg[31:1]}; fit_neg = neg_reg;
                    fitv = fit(fit_mag, fit_neg);
                    if (fitv[32]) st_next = i32alu_pkg::ST_RANGE;
                    else res_next = fitv[31:0];
                end
            end
            S_DIV: begin
                // Restoring divide: remainder in [63:32], quotient in [31:0].
                add_x = {acc_reg[63:31]};
                add_y = {1'b0, mc_reg};
                add_sub = 1'b1;
                if (!add_s[32]) acc_next = {add_s[31:0], acc_reg[30:0], 1'b1};
                else acc_next = {acc_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) state_next = S_FIN;
                if (cnt_reg == 6'd31) begin
                    if (op_reg == i32alu_pkg::OP_DIV) begin
                        fit_mag = {32'd0, acc_next[31:0]}; fit_neg = neg_reg;
                    end else begin
                        fit_mag = {32'd0, acc_next[63:32]}; fit_neg = rneg_reg;
                    end
                    fitv = fit(fit_mag, fit_neg);
                    if (fitv[32]) st_next = i32alu_pkg::ST_RANGE;
                    else res_next = fitv[31:0];
                end
            end
            S_PMUL: begin
                // acc *= |base| through the multiply loop; |base| >= 2 so at most
                // 32 rounds before the magnitude exceeds 2^31.
                if (pexp_reg == 32'd0) begin
                    state_next = S_FIN;
                    fit_mag = acc_reg; fit_neg = pacc_neg_reg;
                    fitv = fit(fit_mag, fit_neg);
                    if (fitv[32]) st_next = i32alu_pkg::ST_RANGE;
                    else res_next = fitv[31:0];
                end else if (acc_reg[63:31] != 33'd0 &&
                             !(acc_reg == 64'h8000_0000 && pacc_neg_reg)) begin
                    state_next = S_FIN;
                    st_next = i32alu_pkg::ST_RANGE;
                end else begin
                    mc_next = pbase_reg; mp_next = acc_reg[31:0];
                    acc_next = 64'd0; cnt_next = 6'd0;
                    pexp_next = pexp_reg - 32'd1;
                    pacc_neg_next = pacc_neg_reg ^ pneg_reg;
                    op_next = i32alu_pkg::OP_POW;
                    state_next = S_MUL;
                end
            end
            S_FIN: begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        // A multiply round that belongs to a power goes back to the power loop.
        if (state_reg == S_MUL && cnt_reg == 6'd31 && op_reg == i32alu_pkg::OP_POW) begin
            state_next = S_PMUL;
            st_next = st_reg;
            res_next = res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        op_reg <= op_next; cnt_reg <= cnt_next; acc_reg <= acc_next;
        mc_reg <= mc_next; mp_reg <= mp_next; neg_reg <= neg_next;
        rneg_reg <= rneg_next; pbase_reg <= pbase_next; pneg_reg <= pneg_next;
        pexp_reg <= pexp_next; pacc_neg_reg <= pacc_neg_next;
        st_reg <= st_next; res_reg <= res_next;
    end

    assign done = done_reg;
    assign rsp.result_value = res_reg;
    assign rsp.status = st_reg;

endmodule

### src/int32_alu_with_range_check_unit.sv
// ----------------------------------------------------------------------------
// int32_alu_with_range_check_unit: signed 32-bit ALU with range check
// Accepts one operation transaction, returns one checked result transaction.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries an operation code and two signed 32-bit operands;
// the m_ channel returns a 32-bit signed result and a status (ok, out of
// range, divide by zero). Both channels use valid/ready handshakes.
// Add, subtract, compare and all special cases are settled on acceptance
// and pass through the finish state, the core's done register and the
// output register to m_valid. Multiply, divide and remainder first run
// the 32 steps of the shared add/subtract unit. Power runs one round (a
// range check plus a 32-step multiply) per exponent step and stops early
// once the magnitude leaves the int32 range.
// The block handles one transaction at a time: s_ready is high only while
// no transaction is in flight and the output register is empty.
// When the receiver stalls, the result is held in the output register and
// no new transaction is accepted until it is taken.
// Reset (aresetn low, synchronous) empties the output register and returns
// the sequencer to idle.
// ----------------------------------------------------------------------------
module int32_alu_with_range_check_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  i32alu_pkg::req_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output i32alu_pkg::rsp_t  m_data
);

    logic busy_reg, busy_next;
    logic ovld_reg, ovld_next;
    i32alu_pkg::rsp_t out_reg;
    i32alu_pkg::dp_cmd_t cmd;
    i32alu_pkg::rsp_t core_rsp;
    logic core_done;
    logic s_fire;

    assign s_ready = !busy_reg && !ovld_reg;
    assign s_fire  = s_valid && s_ready;
    assign cmd.start = s_fire;
    assign cmd.op    = s_data.req_type;

    i32alu_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .a_in    (s_data.operand_a),
        .b_in    (s_data.operand_b),
        .done    (core_done),
        .rsp     (core_rsp)
    );

    // Busy covers the time the core is working; the output register holds
    // the finished transaction until the receiver takes it.
    always_comb begin
        busy_next = busy_reg;
        ovld_next = ovld_reg;
        if (s_fire) busy_next = 1'b1;
        if (core_done) begin
            busy_next = 1'b0;
            ovld_next = 1'b1;
        end
        if (ovld_reg && m_ready) ovld_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ovld_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            ovld_reg <= ovld_next;
        end
        if (core_done) out_reg <= core_rsp;
    end

    assign m_valid = ovld_reg;
    assign m_data  = out_reg;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for int32_alu_with_range_check_unit
// Directed corner cases for every operation, then random transactions with
// random idle gaps and receiver stalls, each result checked against an
// in-bench model of the exact arithmetic and the int32 range check.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 4_000_000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    i32alu_pkg::req_t s_data;
    logic m_valid;
    logic m_ready;
    i32alu_pkg::rsp_t m_data;

    // Results still owed by the block, oldest first.
    i32alu_pkg::rsp_t pending_results[$];
    int   mismatch_count;
    int   cycle_count;
    logic stall_enable;

    int32_alu_with_range_check_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Computes the exact result of one operation and applies the range check.
    function automatic i32alu_pkg::rsp_t alu_result(i32alu_pkg::req_t req);
        i32alu_pkg::rsp_t   rsp;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] r;
        logic signed [63:0] acc;
        logic [1:0]         st;
        a  = req.operand_a;
        b  = req.operand_b;
        r  = 0;
        st = i32alu_pkg::ST_OK;
        case (req.req_type)
            i32alu_pkg::OP_ADD: r = a + b;
            i32alu_pkg::OP_SUB: r = a - b;
            i32alu_pkg::OP_MUL: r = a * b;
            i32alu_pkg::OP_MOD: begin
                if (b == 0) st = i32alu_pkg::ST_DIVZERO;
                else r = a % b;
            end
            i32alu_pkg::OP_DIV: begin
                if (b == 0) st = i32alu_pkg::ST_DIVZERO;
                else r = a / b;
            end
            i32alu_pkg::OP_CMP: r = (a == b) ? 0 : ((a < b) ? -1 : 1);
            i32alu_pkg::OP_POW: begin
                if (b == 0 || a == 1) begin
                    r = 1;
                end else if (a == -1) begin
                    r = b[0] ? -1 : 1;
                end else if (b < 0) begin
                    if (a == 0) st = i32alu_pkg::ST_RANGE;
                    else r = 0;
                end else if (a == 0) begin
                    r = 0;
                end else begin
                    // With |a| >= 2 the value leaves the range within 32 steps.
                    acc = 1;
                    for (longint i = 0; i < b; i++) begin
                        acc = acc * a;
                        if (acc < INT_MIN || acc > INT_MAX) begin
                            st = i32alu_pkg::ST_RANGE;
                            break;
                        end
                    end
                    r = acc;
                end
            end
            default: st = i32alu_pkg::ST_RANGE;
        endcase
        if (st == i32alu_pkg::ST_OK && (r < INT_MIN || r > INT_MAX)) st = i32alu_pkg::ST_RANGE;
        if (st != i32alu_pkg::ST_OK) r = 0;
        rsp.result_value = r[31:0];
        rsp.status       = st;
        return rsp;
    endfunction

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Sends one transaction and records the result it must produce.
    // Valid stays high straight into the next transaction when there is no gap.
    task automatic send_op(logic [2:0] op, logic signed [31:0] a, logic signed [31:0] b);
        i32alu_pkg::req_t req;
        int               gap;
        req.req_type  = op;
        req.operand_a = a;
        req.operand_b = b;
        gap = stall_enable ? gap_length() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        pending_results.push_back(alu_result(req));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Result checker: the receiver stalls at random while enabled.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result transaction: value %0d status %0d",
                                 m_data.result_value, m_data.status);
                end else begin
                    i32alu_pkg::rsp_t want;
                    want = pending_results.pop_front();
                    if (m_data.result_value !== want.result_value ||
                        m_data.status !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Mismatch: expected %0d/%0d, got %0d/%0d",
                                     want.result_value, want.status,
                                     m_data.result_value, m_data.status);
                    end
                end
            end
            m_ready <= stall_enable ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic signed [31:0] random_word();
        logic signed [31:0] w;
        int pick;
        pick = $urandom_range(0, 9);
        w = $urandom;
        case (pick)
            0: w = INT_MIN + $urandom_range(0, 2);
            1: w = INT_MAX - $urandom_range(0, 2);
            2: w = $signed($urandom_range(0, 8)) - 4;
            3: w = $signed($urandom_range(0, 131072)) - 65536;
            default: ;
        endcase
        return w;
    endfunction

    task automatic test_directed();
        send_op(i32alu_pkg::OP_ADD, INT_MAX, 1);
        send_op(i32alu_pkg::OP_ADD, INT_MIN, -1);
        send_op(i32alu_pkg::OP_ADD, INT_MIN, INT_MAX);
        send_op(i32alu_pkg::OP_SUB, INT_MIN, 1);
        send_op(i32alu_pkg::OP_SUB, 0, INT_MIN);
        send_op(i32alu_pkg::OP_SUB, -1, INT_MIN);
        send_op(i32alu_pkg::OP_MUL, INT_MIN, -1);
        send_op(i32alu_pkg::OP_MUL, 65536, 32768);
        send_op(i32alu_pkg::OP_MUL, -65536, 32768);
        send_op(i32alu_pkg::OP_MOD, 7, 0);
        send_op(i32alu_pkg::OP_MOD, INT_MIN, -1);
        send_op(i32alu_pkg::OP_MOD, -7, 3);
        send_op(i32alu_pkg::OP_DIV, INT_MIN, -1);
        send_op(i32alu_pkg::OP_DIV, -7, 2);
        send_op(i32alu_pkg::OP_DIV, 5, 0);
        send_op(i32alu_pkg::OP_POW, 0, 0);
        send_op(i32alu_pkg::OP_POW, 0, -3);
        send_op(i32alu_pkg::OP_POW, -1, -5);
        send_op(i32alu_pkg::OP_POW, -1, INT_MIN);
        send_op(i32alu_pkg::OP_POW, 1, INT_MIN);
        send_op(i32alu_pkg::OP_POW, 5, -2);
        send_op(i32alu_pkg::OP_POW, -2, 31);
        send_op(i32alu_pkg::OP_POW, 2, 31);
        send_op(i32alu_pkg::OP_CMP, INT_MIN, INT_MAX);
        send_op(OP_UNUSED, INT_MAX, INT_MAX);
    endtask

    task automatic test_random();
        logic [2:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        for (int n = 0; n < 1600; n++) begin
            op = $urandom_range(0, 7);
            a  = random_word();
            b  = random_word();
            // Keep power exponents mostly small so the results stay varied.
            if (op == i32alu_pkg::OP_POW && $urandom_range(0, 3) != 0) begin
                b = $signed($urandom_range(0, 34)) - 2;
                if ($urandom_range(0, 1)) a = $signed($urandom_range(0, 20)) - 10;
            end
            if (op == i32alu_pkg::OP_CMP && $urandom_range(0, 3) == 0) b = a;
            // A stretch without any idling on either side.
            stall_enable = !(n >= 800 && n < 900);
            send_op(op, a, b);
        end
        stall_enable = 1'b1;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        stall_enable   = 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### files.f
src/i32alu_pkg.sv
src/i32alu_core.sv
src/int32_alu_with_range_check_unit.sv
test/testbench.sv
